// ===== sv/ipps_pkg.sv =====
// Shared types and constants of the projection profile block.
package ipps_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 20;
    localparam int IDX_W      = 12;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_ADDR_W-1:0] CFG_AXIS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic row_end;
        logic last_row;
        logic first_row;
    } t_pos_flags;

endpackage

// ===== sv/ipps_cfg.sv =====
// Configuration registers with dimension clamping.
module ipps_cfg #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int CW         = 12,
    parameter int RW         = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ipps_pkg::CFG_ADDR_W-1:0]   i_cfg_index,
    input  logic [ipps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_axis,
    output logic [CW-1:0]                     o_col_last,
    output logic [RW-1:0]                     o_row_last
);
    import ipps_pkg::*;

    localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    logic          r_axis;
    logic [CW-1:0] r_col_last;
    logic [RW-1:0] r_row_last;
    logic [CW-1:0] n_col_last;
    logic [RW-1:0] n_row_last;

    // zero acts as one, oversize acts as the maximum
    always_comb begin
        if (i_cfg_data == '0) begin
            n_col_last = '0;
        end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
            n_col_last = CW'(32'(MAX_WIDTH) - 32'd1);
        end else begin
            n_col_last = CW'(32'(i_cfg_data) - 32'd1);
        end
        if (i_cfg_data == '0) begin
            n_row_last = '0;
        end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
            n_row_last = RW'(32'(MAX_HEIGHT) - 32'd1);
        end else begin
            n_row_last = RW'(32'(i_cfg_data) - 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis     <= 1'b0;
            r_col_last <= CW'(W_RST - 1);
            r_row_last <= RW'(H_RST - 1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_AXIS:   r_axis     <= i_cfg_data[0];
                CFG_WIDTH:  r_col_last <= n_col_last;
                CFG_HEIGHT: r_row_last <= n_row_last;
                default:    ;
            endcase
        end
    end

    assign o_axis     = r_axis;
    assign o_col_last = r_col_last;
    assign o_row_last = r_row_last;

endmodule

// ===== sv/ipps_pos.sv =====
// Raster position counters for the incoming pixel stream.
module ipps_pos #(
    parameter int CW = 12,
    parameter int RW = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_restart,
    input  logic                 i_accept,
    input  logic [CW-1:0]        i_col_last,
    input  logic [RW-1:0]        i_row_last,
    output logic [CW-1:0]        o_col,
    output logic [RW-1:0]        o_row,
    output ipps_pkg::t_pos_flags o_flags
);
    import ipps_pkg::*;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    t_pos_flags    flags;

    always_comb begin
        flags.row_end   = (r_col == i_col_last);
        flags.last_row  = (r_row == i_row_last);
        flags.first_row = (r_row == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (flags.row_end) begin
                r_col <= '0;
                r_row <= flags.last_row ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    assign o_col   = r_col;
    assign o_row   = r_row;
    assign o_flags = flags;

`ifndef SYNTH
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= i_col_last) else $error("column position beyond row width");
    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= i_row_last) else $error("row position beyond frame height");
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && flags.row_end) |=> (r_col == '0))
        else $error("column did not wrap at row end");
`endif

endmodule

// ===== sv/ipps_colmem.sv =====
// Column sum memory: one write port, one registered read port.
module ipps_colmem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [ipps_pkg::SUM_W-1:0]  o_rd_data,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [ipps_pkg::SUM_W-1:0]  i_wr_data
);
    import ipps_pkg::*;

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-first: a same-address write in this cycle is not seen
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/image_projection_profile_sum.sv =====
// Projection profile of a raster grayscale frame: one sum per row, or one per column.
// Takes one pixel every clock cycle, sustained, in both modes. A pixel is taken into
// the sum stage, and its column memory read is issued on the same edge. The sum stage
// does the row accumulation or the read-modify-write of the column memory, and loads
// the output register, from which each result is driven. A result held by an output
// stall holds the whole pipe and raises the input stall. The column memory holds
// MAX_WIDTH sums; the first row of each frame writes them before any read result is
// used, so no clearing pass is needed after reset. Any configuration write restarts
// the frame at row 0, column 0; write only while the block is idle.
module image_projection_profile_sum #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ipps_pkg::CFG_ADDR_W-1:0]  i_cfg_index,
    input  logic [ipps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [ipps_pkg::PIX_W-1:0]       i_pixel_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ipps_pkg::SUM_W-1:0]       o_line_sum,
    output logic [ipps_pkg::IDX_W-1:0]       o_line_index,
    output logic                             o_frame_last
);
    import ipps_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic          cfg_axis;
    logic [CW-1:0] cfg_col_last;
    logic [RW-1:0] cfg_row_last;

    logic          en;
    logic          accept;
    logic [CW-1:0] pos_col;
    logic [RW-1:0] pos_row;
    t_pos_flags    pos_flags;

    logic [SUM_W-1:0] mem_rd_data;

    // sum stage
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic [CW-1:0]    r_s1_col;
    logic [RW-1:0]    r_s1_row;
    t_pos_flags       r_s1_flags;
    logic             r_fwd;
    logic [SUM_W-1:0] r_fwd_data;
    logic [SUM_W-1:0] r_acc;

    logic [SUM_W-1:0] col_base;
    logic [SUM_W-1:0] col_total;
    logic [SUM_W-1:0] acc_sum;
    logic             s1_emit;
    logic             s1_wr;
    logic [SUM_W-1:0] s1_sum;
    logic [IDX_W-1:0] s1_index;
    logic             s1_last;

    // output register
    logic             r_out_valid;
    logic [SUM_W-1:0] r_out_sum;
    logic [IDX_W-1:0] r_out_index;
    logic             r_out_last;

    ipps_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_axis      (cfg_axis),
        .o_col_last  (cfg_col_last),
        .o_row_last  (cfg_row_last)
    );

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;
    assign accept     = i_in_valid && en;

    ipps_pos #(
        .CW (CW),
        .RW (RW)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (i_cfg_we),
        .i_accept   (accept),
        .i_col_last (cfg_col_last),
        .i_row_last (cfg_row_last),
        .o_col      (pos_col),
        .o_row      (pos_row),
        .o_flags    (pos_flags)
    );

    ipps_colmem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_colmem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (pos_col),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (en && s1_wr),
        .i_wr_addr (r_s1_col),
        .i_wr_data (col_total)
    );

    always_comb begin
        // a one-pixel-wide frame reads the column being written in the same cycle
        col_base  = r_fwd ? r_fwd_data : mem_rd_data;
        col_total = r_s1_flags.first_row ? SUM_W'(r_s1_pix) : col_base + SUM_W'(r_s1_pix);
        acc_sum   = r_acc + SUM_W'(r_s1_pix);
        s1_emit   = cfg_axis ? r_s1_flags.last_row : r_s1_flags.row_end;
        s1_wr     = r_s1_valid && cfg_axis && !r_s1_flags.last_row;
        if (cfg_axis) begin
            s1_sum   = col_total;
            s1_index = IDX_W'(32'(r_s1_col));
            s1_last  = r_s1_flags.row_end;
        end else begin
            s1_sum   = acc_sum;
            s1_index = IDX_W'(32'(r_s1_row));
            s1_last  = r_s1_flags.last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= accept;
            r_fwd       <= accept && s1_wr && (r_s1_col == pos_col);
            r_out_valid <= r_s1_valid && s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_acc <= '0;
        end else if (en && r_s1_valid && !cfg_axis) begin
            r_acc <= r_s1_flags.row_end ? '0 : acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix   <= i_pixel_value;
            r_s1_col   <= pos_col;
            r_s1_row   <= pos_row;
            r_s1_flags <= pos_flags;
            r_fwd_data <= col_total;
        end
        if (en && r_s1_valid && s1_emit) begin
            r_out_sum   <= s1_sum;
            r_out_index <= s1_index;
            r_out_last  <= s1_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_sum   = r_out_sum;
    assign o_line_index = r_out_index;
    assign o_frame_last = r_out_last;

`ifndef SYNTH
    a_fwd_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid) else $error("forwarded sum without a beat in the sum stage");
    a_fwd_not_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fwd && r_s1_valid) |-> !r_s1_flags.first_row)
        else $error("forwarded sum on the first row of a frame");
    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s1_valid && s1_emit) |=> r_out_valid)
        else $error("result lost between sum stage and output");
`endif

endmodule
